### hw/rtl/sqs_pkg.sv
// Package for the sample quantile selector.
// Holds configuration indexes, method codes and level constants; no dependencies.
`default_nettype none
package sqs_pkg;

   localparam int DEF_MAX_SAMPLES = 256;
   localparam int DEF_SAMPLE_BITS = 32;

   localparam int FIELD_BITS = 32;
   localparam int LEVEL_BITS = 17;
   localparam int METHOD_BITS = 2;
   localparam int FRAC_BITS = 16;

   localparam logic CSR_LEVEL = 1'b0;
   localparam logic CSR_METHOD = 1'b1;

   localparam logic [METHOD_BITS-1:0] METHOD_TYPE1 = 2'd0;
   localparam logic [METHOD_BITS-1:0] METHOD_TYPE2 = 2'd1;
   localparam logic [METHOD_BITS-1:0] METHOD_TYPE3 = 2'd2;

   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = 17'd65536;
   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 17'd32768;
   localparam logic [FRAC_BITS-1:0] FRAC_HALF = 16'd32768;

endpackage
`default_nettype wire

### hw/rtl/sqs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used by the sample quantile selector for the sample store.
`default_nettype none
module sqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sample_quantile_select.sv
// Sample quantile selector, top level.
// Depends on sqs_pkg and sqs_ram.
//
// Samples arrive as beats on the req_ channel, one sample per beat, with
// req_tlast on the final sample of a set. Each accepted sample is inserted
// into a RAM that is kept in ascending order: every stored entry larger
// than it is moved up one place per cycle, then the sample is written in
// the freed place; the first sample of a set is written directly and a
// dropped sample is not written. After the last sample the block forms
// n * p, reads one or two order statistics from the RAM in states ST_MUL,
// ST_IDX, ST_RDA and ST_RDB, and raises rsp_tvalid once the result is loaded
// into the output register in ST_OUT. The result beat on rsp_ carries the
// quantile and a flag that samples were dropped because the store was full.
// req_tready is high only while no insertion or selection is in progress.
// A stalled result stays in its register while new samples are still taken;
// the next set only waits if its own result is ready before the old one is
// taken. Reset clears the sample count, the overflow flag, the pending result
// and restores the level to one half and the method to type 1. The RAM needs
// no clearing pass.
`default_nettype none
module sample_quantile_select
   import sqs_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [FIELD_BITS-1:0]   req_tdata,   // [31:0] sample_value
   input  wire                    req_tlast,   // last_sample
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [FIELD_BITS-1:0]  rsp_tdata,   // [31:0] quantile_value
   output logic                   rsp_tuser,   // set_overflow
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [LEVEL_BITS-1:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int TW = CW + LEVEL_BITS;
   localparam int KW = CW + 2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SHIFT, ST_PLACE, ST_MUL, ST_IDX, ST_RDA, ST_RDB, ST_OUT
   } state_type;

   state_type                state_ff;
   logic [CW-1:0]            count_ff;
   logic                     overflow_ff;
   logic [AW-1:0]            pos_ff;
   logic [SAMPLE_BITS-1:0]   val_ff;
   logic                     last_ff;
   logic [LEVEL_BITS-1:0]    level_ff;
   logic [METHOD_BITS-1:0]   method_ff;
   logic [TW-1:0]            t_ff;
   logic [AW-1:0]            kb_addr_ff;
   logic                     avg_ff;
   logic [SAMPLE_BITS-1:0]   a_ff;
   logic [SAMPLE_BITS-1:0]   res_ff;
   logic                     rsp_tvalid_ff;
   logic [SAMPLE_BITS-1:0]   rsp_data_ff;
   logic                     rsp_ovf_ff;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [SAMPLE_BITS-1:0]   wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [SAMPLE_BITS-1:0]   rd_data;

   logic                     accept;
   logic                     store_full;
   logic                     move_up;
   logic                     out_load;
   logic [SAMPLE_BITS-1:0]   in_sample;
   logic [LEVEL_BITS-1:0]    p_clamp;
   logic [TW:0]              u_sum;
   logic [KW-1:0]            hi_k;
   logic [KW-1:0]            hu_k;
   logic [KW-1:0]            ka_k;
   logic [KW-1:0]            kb_k;
   logic                     avg_in;
   logic [AW-1:0]            ka_addr;
   logic [AW-1:0]            kb_addr;
   logic [SAMPLE_BITS-1:0]   avg_value;
   logic [63:0]              res_ext;

   function automatic logic [AW-1:0] order_addr(input logic [KW-1:0] k,
                                               input logic [CW-1:0] n);
      logic [KW-1:0] kc;
      begin
         kc = k;
         if (kc == '0) begin
            kc = KW'(1);
         end
         if (kc > KW'(n)) begin
            kc = KW'(n);
         end
         order_addr = AW'(kc - KW'(1));
      end
   endfunction

   sqs_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign store_full = (count_ff == CW'(MAX_SAMPLES));
   assign in_sample = SAMPLE_BITS'(64'(signed'(req_tdata)));
   assign move_up = $signed(val_ff) < $signed(rd_data);
   assign out_load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   assign p_clamp = (level_ff > LEVEL_ONE) ? LEVEL_ONE : level_ff;
   assign u_sum = (TW+1)'(t_ff) + (TW+1)'(FRAC_HALF);
   assign hi_k = KW'(t_ff >> FRAC_BITS);
   assign hu_k = KW'(u_sum >> FRAC_BITS);

   always_comb begin
      ka_k = hi_k;
      kb_k = hi_k;
      avg_in = 1'b0;
      unique case (method_ff)
         METHOD_TYPE2: begin
            if (t_ff[FRAC_BITS-1:0] != '0) begin
               ka_k = hi_k + KW'(1);
               kb_k = ka_k;
            end else begin
               kb_k = hi_k + KW'(1);
               avg_in = 1'b1;
            end
         end
         METHOD_TYPE3: begin
            if (u_sum[FRAC_BITS-1:0] == '0 && hu_k[0]) begin
               ka_k = hu_k - KW'(1);
            end else begin
               ka_k = hu_k;
            end
            kb_k = ka_k;
         end
         default: begin
            if (t_ff[FRAC_BITS-1:0] != '0) begin
               ka_k = hi_k + KW'(1);
            end
            kb_k = ka_k;
         end
      endcase
   end

   assign ka_addr = order_addr(ka_k, count_ff);
   assign kb_addr = order_addr(kb_k, count_ff);

   assign avg_value = avg_ff
      ? SAMPLE_BITS'(($signed(a_ff) >>> 1) + ($signed(rd_data) >>> 1)
                     + $signed({1'b0, a_ff[0] & rd_data[0]}))
      : a_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = val_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !store_full) begin
               if (count_ff == '0) begin
                  wr_en = 1'b1;
                  wr_addr = '0;
                  wr_data = in_sample;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = AW'(count_ff - CW'(1));
               end
            end
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (move_up) begin
               wr_data = rd_data;
               if (pos_ff != AW'(1)) begin
                  rd_en = 1'b1;
                  rd_addr = pos_ff - AW'(2);
               end
            end
         end
         ST_PLACE: begin
            wr_en = 1'b1;
            wr_addr = '0;
         end
         ST_IDX: begin
            rd_en = 1'b1;
            rd_addr = ka_addr;
         end
         ST_RDA: begin
            rd_en = 1'b1;
            rd_addr = kb_addr_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         overflow_ff <= 1'b0;
         level_ff <= LEVEL_RESET;
         method_ff <= METHOD_TYPE1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEVEL:  level_ff <= csr_wdata;
               CSR_METHOD: method_ff <= csr_wdata[METHOD_BITS-1:0];
            endcase
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_ff <= req_tlast;
                  val_ff <= in_sample;
                  pos_ff <= AW'(count_ff);
                  if (store_full) begin
                     overflow_ff <= 1'b1;
                     state_ff <= req_tlast ? ST_MUL : ST_IDLE;
                  end else if (count_ff == '0) begin
                     count_ff <= CW'(1);
                     state_ff <= req_tlast ? ST_MUL : ST_IDLE;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                     state_ff <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               if (move_up) begin
                  pos_ff <= pos_ff - AW'(1);
                  if (pos_ff == AW'(1)) begin
                     state_ff <= ST_PLACE;
                  end
               end else begin
                  state_ff <= last_ff ? ST_MUL : ST_IDLE;
               end
            end
            ST_PLACE: begin
               state_ff <= last_ff ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
               t_ff <= TW'(count_ff) * TW'(p_clamp);
               state_ff <= ST_IDX;
            end
            ST_IDX: begin
               kb_addr_ff <= kb_addr;
               avg_ff <= avg_in;
               state_ff <= ST_RDA;
            end
            ST_RDA: begin
               a_ff <= rd_data;
               state_ff <= ST_RDB;
            end
            ST_RDB: begin
               res_ff <= avg_value;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_data_ff <= res_ff;
                  rsp_ovf_ff <= overflow_ff;
                  count_ff <= '0;
                  overflow_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign res_ext = 64'(signed'(rsp_data_ff));
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = res_ext[FIELD_BITS-1:0];
   assign rsp_tuser = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count above store depth");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (pos_ff != '0))
      else $error("insertion position reached zero while shifting");

   a_select_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDX) |-> (count_ff != '0))
      else $error("selection started on an empty set");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (count_ff == '0) && !overflow_ff && rsp_tvalid_ff)
      else $error("set state not cleared after result load");

endmodule
`default_nettype wire
